### hw/rtl/resp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// resp_pkg
// Types and constants shared by the RESP2 reply parser modules.
// ----------------------------------------------------------------------------
package resp_pkg;

    typedef enum logic [3:0] {
        M_FRESH,
        M_TYPE,
        M_TYPE_NOSER,
        M_SERIAL,
        M_LINE,
        M_NUMBER,
        M_BULK,
        M_TRAIL
    } mode_t;

    localparam logic [2:0] EV_NONE   = 3'd0;
    localparam logic [2:0] EV_DATA   = 3'd1;
    localparam logic [2:0] EV_STREND = 3'd2;
    localparam logic [2:0] EV_INT    = 3'd3;
    localparam logic [2:0] EV_NIL    = 3'd4;
    localparam logic [2:0] EV_ARRAY  = 3'd5;
    localparam logic [2:0] EV_SERIAL = 3'd6;
    localparam logic [2:0] EV_ERROR  = 3'd7;

    localparam logic [2:0] T_ERR  = 3'd0;
    localparam logic [2:0] T_STAT = 3'd1;
    localparam logic [2:0] T_INT  = 3'd2;
    localparam logic [2:0] T_BULK = 3'd3;
    localparam logic [2:0] T_ARR  = 3'd4;

    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_DOLL  = 8'h24;
    localparam logic [7:0] CH_STAR  = 8'h2a;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    localparam logic [1:0] NR_GOON = 2'd0;
    localparam logic [1:0] NR_DONE = 2'd1;
    localparam logic [1:0] NR_LONG = 2'd2;

    // datapath status to controller: number line, hold byte and bulk counter
    typedef struct packed {
        logic [1:0] result;
        logic       value_neg;
        logic       count_nil;
        logic       count_pos;
        logic       bulk_zero;
        logic       bulk_last;
        logic       hold_crlf;
        logic       hold_valid;
        logic       cr_pending;
    } dp_stat_t;

    // datapath commands
    typedef struct packed {
        logic num_start;
        logic num_byte;
        logic line_byte;
        logic hold_clear;
        logic bulk_load;
        logic bulk_dec;
        logic cr_set;
        logic cr_clear;
    } dp_cmd_t;

endpackage
`default_nettype wire

### hw/rtl/resp_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// resp_datapath
// Number line accumulator, status line hold byte and bulk byte counter.
// ----------------------------------------------------------------------------
module resp_datapath
    import resp_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [7:0]  in_byte,
    input  wire logic [6:0]  line_limit,
    input  wire dp_cmd_t     cmd,
    output dp_stat_t         stat,
    output logic [63:0]      num_value,
    output logic [7:0]       hold_byte
);
    logic [63:0] accum_reg, accum_next;
    logic        neg_reg, neg_next;
    logic        bad_reg, bad_next;
    logic [6:0]  dcnt_reg, dcnt_next;
    logic        cr_reg, cr_next;
    logic [63:0] bulk_reg, bulk_next;
    logic [7:0]  hold_reg, hold_next;
    logic        hv_reg, hv_next;
    logic [63:0] cnt_ext;
    logic [63:0] acc_a;
    logic        neg_a, bad_a;
    logic [6:0]  dcnt_a;
    logic        do_content;
    logic [7:0]  cbyte;
    logic [1:0]  nr_res;

    always_comb begin
        num_value = bad_reg ? '1 : (neg_reg ? (64'd0 - accum_reg) : accum_reg);
        if (COUNT_WIDTH >= 64) begin
            cnt_ext = num_value;
        end else begin
            cnt_ext = 64'(signed'(num_value[COUNT_WIDTH-1:0]));
        end
    end

    // content of one number byte, given the current state
    function automatic void content(input logic [7:0] b, input logic [63:0] ai,
                                    input logic ni, input logic bi, input logic [6:0] di,
                                    output logic [63:0] ao, output logic no,
                                    output logic bo, output logic [6:0] dout);
        ao = ai; no = ni; bo = bi; dout = di;
        if (di == 7'd0 && (b == CH_MINUS || b == CH_PLUS)) begin
            no = (b == CH_MINUS);
        end else if (b >= CH_0 && b <= CH_9) begin
            ao = (ai << 3) + (ai << 1) + {60'd0, b[3:0]};
        end else begin
            bo = 1'b1;
        end
        if (di != 7'd127) dout = di + 7'd1;
    endfunction

    always_comb begin
        accum_next = accum_reg; neg_next = neg_reg; bad_next = bad_reg;
        dcnt_next = dcnt_reg; cr_next = cr_reg; bulk_next = bulk_reg;
        hold_next = hold_reg; hv_next = hv_reg;
        nr_res = NR_GOON;
        acc_a = accum_reg; neg_a = neg_reg; bad_a = bad_reg; dcnt_a = dcnt_reg;
        do_content = 1'b0; cbyte = in_byte;
        if (cr_reg && in_byte == CH_LF) begin
            nr_res = (dcnt_reg >= line_limit) ? NR_LONG : NR_DONE;
        end else if (cr_reg) begin
            content(CH_CR, accum_reg, neg_reg, bad_reg, dcnt_reg, acc_a, neg_a, bad_a, dcnt_a);
        end
        if (in_byte != CH_CR) begin
            do_content = 1'b1;
        end
        if (cmd.num_byte && !(cr_reg && in_byte == CH_LF)) begin
            if (do_content) begin
                content(cbyte, acc_a, neg_a, bad_a, dcnt_a,
                        accum_next, neg_next, bad_next, dcnt_next);
            end else begin
                accum_next = acc_a; neg_next = neg_a; bad_next = bad_a; dcnt_next = dcnt_a;
            end
            cr_next = (in_byte == CH_CR);
        end else if (cmd.num_byte) begin
            cr_next = 1'b0;
        end
        if (cmd.num_start) begin
            accum_next = '0; neg_next = 1'b0; bad_next = 1'b0;
            dcnt_next = '0; cr_next = 1'b0;
        end
        if (cmd.bulk_load) bulk_next = num_value;
        if (cmd.bulk_dec) bulk_next = bulk_reg - 64'd1;
        if (cmd.cr_set) cr_next = 1'b1;
        if (cmd.cr_clear) cr_next = 1'b0;
        if (cmd.line_byte) begin
            hold_next = in_byte;
            hv_next = 1'b1;
        end
        if (cmd.hold_clear) hv_next = 1'b0;
    end

    always_comb begin
        stat.result = nr_res;
        stat.value_neg = num_value[63];
        stat.count_nil = (cnt_ext == '1);
        stat.count_pos = (cnt_ext != 64'd0) && !cnt_ext[63];
        stat.bulk_zero = (num_value == 64'd0);
        stat.bulk_last = (bulk_reg == 64'd1);
        stat.hold_crlf = hv_reg && hold_reg == CH_CR && in_byte == CH_LF;
        stat.hold_valid = hv_reg;
        stat.cr_pending = cr_reg;
        hold_byte = hv_reg ? hold_reg : 8'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accum_reg <= '0; neg_reg <= 1'b0; bad_reg <= 1'b0; dcnt_reg <= '0;
            cr_reg <= 1'b0; bulk_reg <= '0; hv_reg <= 1'b0; hold_reg <= '0;
        end else begin
            accum_reg <= accum_next; neg_reg <= neg_next; bad_reg <= bad_next;
            dcnt_reg <= dcnt_next; cr_reg <= cr_next; bulk_reg <= bulk_next;
            hv_reg <= hv_next; hold_reg <= hold_next;
        end
    end
endmodule
`default_nettype wire

### hw/rtl/resp_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// resp_controller
// Parse mode state machine and array nesting stack.
// ----------------------------------------------------------------------------
module resp_controller
    import resp_pkg::*;
#(
    parameter int MAX_DEPTH   = 8,
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        step,
    input  wire logic [7:0]  in_byte,
    input  wire logic        restart,
    input  wire logic [15:0] pipe_count,
    input  wire dp_stat_t    stat,
    input  wire logic [63:0] num_value,
    input  wire logic [7:0]  hold_byte,
    output dp_cmd_t          cmd,
    output logic [2:0]       ev,
    output logic [2:0]       etype,
    output logic [63:0]      val,
    output logic [7:0]       dat,
    output logic [3:0]       lvl,
    output logic             done
);
    localparam int SW = $clog2(MAX_DEPTH + 1);
    localparam int RW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    mode_t mode_reg, mode_next, mode_eff;
    logic [RW-1:0] rem_reg [MAX_DEPTH+1];
    logic [RW-1:0] idx_reg [MAX_DEPTH+1];
    logic [SW-1:0] top_reg, top_next, top_eff, pop_top;
    logic [2:0] typ_reg, typ_next;
    logic ser_reg, ser_next, err_reg, err_next;
    logic err_eff, fresh, pipe, finish, fail, push, adv_done;
    logic [MAX_DEPTH:0] lvl_last;
    logic [COUNT_WIDTH-1:0] cnt;

    assign pipe = pipe_count > 16'd1;
    assign err_eff = err_reg && !restart;
    assign fresh = !err_eff && (restart || mode_reg == M_FRESH);
    assign mode_eff = fresh ? M_TYPE : mode_reg;
    assign top_eff = fresh ? (pipe ? SW'(1) : SW'(0)) : top_reg;
    assign cnt = num_value[COUNT_WIDTH-1:0];

    // per level: this element is the last of its parent
    always_comb begin
        lvl_last[0] = 1'b1;
        for (int t = 1; t <= MAX_DEPTH; t++) begin
            if (fresh) begin
                lvl_last[t] = (t == 1) ? (RW'(1) >= RW'(pipe_count)) : 1'b1;
            end else begin
                lvl_last[t] = (idx_reg[t] + RW'(1)) >= rem_reg[t-1];
            end
        end
    end

    // pop search: highest level not yet on its last element
    always_comb begin
        pop_top = '0;
        for (int t = 1; t <= MAX_DEPTH; t++) begin
            if (t <= int'(top_eff) && !lvl_last[t]) pop_top = SW'(t);
        end
        adv_done = (pop_top == '0);
    end

    always_comb begin
        cmd = '0; ev = EV_NONE; val = '0; dat = '0; finish = 1'b0; fail = 1'b0;
        push = 1'b0; mode_next = mode_eff; typ_next = typ_reg; ser_next = ser_reg;
        if (fresh) ser_next = 1'b0;
        unique case (mode_eff)
            M_TYPE, M_TYPE_NOSER: begin
                if (in_byte == CH_AT && mode_eff == M_TYPE &&
                    (!(fresh ? 1'b0 : ser_reg) || (pipe && top_eff == SW'(1)))) begin
                    cmd.num_start = 1'b1;
                    mode_next = M_SERIAL;
                end else begin
                    ser_next = 1'b1;
                    cmd.hold_clear = 1'b1;
                    cmd.num_start = 1'b1;
                    unique case (in_byte)
                        CH_MINUS: begin typ_next = T_ERR;  mode_next = M_LINE; end
                        CH_PLUS:  begin typ_next = T_STAT; mode_next = M_LINE; end
                        CH_COLON: begin typ_next = T_INT;  mode_next = M_NUMBER; end
                        CH_DOLL:  begin typ_next = T_BULK; mode_next = M_NUMBER; end
                        CH_STAR: begin
                            typ_next = T_ARR;
                            if (int'(top_eff) >= MAX_DEPTH) fail = 1'b1;
                            else mode_next = M_NUMBER;
                        end
                        default: begin typ_next = T_ERR; fail = 1'b1; end
                    endcase
                end
            end
            M_SERIAL: begin
                cmd.num_byte = 1'b1;
                if (stat.result == NR_LONG) fail = 1'b1;
                else if (stat.result == NR_DONE) begin
                    ev = EV_SERIAL; val = num_value; ser_next = 1'b1;
                    mode_next = M_TYPE_NOSER;
                end
            end
            M_LINE: begin
                if (stat.hold_crlf) begin
                    cmd.hold_clear = 1'b1; ev = EV_STREND; finish = 1'b1;
                end else begin
                    if (stat.hold_valid) begin
                        ev = EV_DATA;
                    end
                    dat = hold_byte;
                    cmd.line_byte = 1'b1;
                end
            end
            M_NUMBER: begin
                cmd.num_byte = 1'b1;
                if (stat.result == NR_LONG) fail = 1'b1;
                else if (stat.result == NR_DONE) begin
                    if (typ_reg == T_BULK) begin
                        if (stat.value_neg) begin ev = EV_NIL; finish = 1'b1; end
                        else begin
                            cmd.bulk_load = 1'b1; cmd.cr_clear = 1'b1;
                            mode_next = stat.bulk_zero ? M_TRAIL : M_BULK;
                        end
                    end else if (typ_reg == T_ARR) begin
                        if (stat.count_nil) begin ev = EV_NIL; finish = 1'b1; end
                        else if (stat.count_pos && int'(top_eff) < MAX_DEPTH) begin
                            ev = EV_ARRAY;
                            val = 64'(signed'(cnt));
                            push = 1'b1;
                            mode_next = M_TYPE;
                        end else begin ev = EV_ARRAY; finish = 1'b1; end
                    end else begin
                        ev = EV_INT; val = num_value; finish = 1'b1;
                    end
                end
            end
            M_BULK: begin
                ev = EV_DATA; dat = in_byte; cmd.bulk_dec = 1'b1;
                if (stat.bulk_last) begin cmd.cr_clear = 1'b1; mode_next = M_TRAIL; end
            end
            M_TRAIL: begin
                if (!stat.cr_pending) cmd.cr_set = 1'b1;
                else begin cmd.cr_clear = 1'b1; ev = EV_STREND; finish = 1'b1; end
            end
            default: mode_next = M_FRESH;
        endcase
        done = 1'b0;
        top_next = top_eff;
        err_next = err_eff;
        if (err_eff) begin
            cmd = '0; ev = EV_ERROR; val = '0; dat = '0;
            mode_next = mode_reg; typ_next = typ_reg; ser_next = ser_reg;
        end else if (fail) begin
            err_next = 1'b1; ev = EV_ERROR; val = '0; dat = '0;
        end else if (push) begin
            top_next = top_eff + SW'(1);
        end else if (finish) begin
            top_next = pop_top;
            if (adv_done) begin done = 1'b1; mode_next = M_FRESH; end
            else mode_next = M_TYPE;
        end
        etype = (ev == EV_NONE || ev == EV_SERIAL) ? 3'd0 : (err_eff ? typ_reg : typ_next);
        lvl = 4'(top_eff);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_FRESH; top_reg <= '0; typ_reg <= '0;
            ser_reg <= 1'b0; err_reg <= 1'b0;
            for (int t = 0; t <= MAX_DEPTH; t++) begin
                rem_reg[t] <= '0; idx_reg[t] <= '0;
            end
        end else if (step) begin
            mode_reg <= mode_next; top_reg <= top_next; typ_reg <= typ_next;
            ser_reg <= ser_next; err_reg <= err_next;
            if (fresh) begin
                for (int t = 0; t <= MAX_DEPTH; t++) begin
                    rem_reg[t] <= '0; idx_reg[t] <= '0;
                end
                if (pipe) rem_reg[0] <= RW'(pipe_count);
            end
            if (!err_eff && !fail && push) begin
                rem_reg[top_eff] <= RW'(cnt);
                idx_reg[top_eff + SW'(1)] <= '0;
            end else if (!err_eff && !fail && finish && !adv_done) begin
                idx_reg[pop_top] <= (fresh ? RW'(0) : idx_reg[pop_top]) + RW'(1);
            end
        end
    end
endmodule
`default_nettype wire

### hw/rtl/resp_reply_stream_parser_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// resp_reply_stream_parser_unit
// RESP2 reply stream parser, one event per input byte.
// ----------------------------------------------------------------------------
// Each accepted byte yields one event transaction. A byte is taken in the
// cycle its valid is seen once the output register is free, so the block
// runs at one byte per cycle while the sink keeps up; the parse state
// updates in the same cycle through the mode controller and the nesting
// stack pop search.
module resp_reply_stream_parser_unit
    import resp_pkg::*;
#(
    parameter int MAX_DEPTH   = 8,
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_in_byte,
    input  wire logic        s_restart,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_event_res,
    output logic [2:0]       m_elem_type,
    output logic signed [63:0] m_value,
    output logic [7:0]       m_data_out,
    output logic [3:0]       m_level,
    output logic             m_reply_done
);
    logic [15:0] pc_reg;
    logic [6:0]  ll_reg;
    logic        step, ov_reg;
    dp_cmd_t     cmd, cmd_g;
    dp_stat_t    stat;
    logic [63:0] num_value, val;
    logic [7:0]  hold_byte, dat;
    logic [2:0]  ev, et;
    logic [3:0]  lvl;
    logic        done;

    assign s_ready = !ov_reg || m_ready;
    assign step = s_valid && s_ready;
    assign cmd_g = step ? cmd : dp_cmd_t'('0);
    assign m_valid = ov_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= 16'd1; ll_reg <= 7'd32;
        end else if (cfg_we) begin
            if (cfg_index == 1'b0) pc_reg <= cfg_data;
            else ll_reg <= cfg_data[6:0];
        end
    end

    resp_datapath #(.COUNT_WIDTH(COUNT_WIDTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .in_byte(s_in_byte), .line_limit(ll_reg),
        .cmd(cmd_g), .stat(stat), .num_value(num_value), .hold_byte(hold_byte)
    );

    resp_controller #(.MAX_DEPTH(MAX_DEPTH), .COUNT_WIDTH(COUNT_WIDTH)) u_ctl (
        .aclk(aclk), .aresetn(aresetn), .step(step), .in_byte(s_in_byte),
        .restart(s_restart), .pipe_count(pc_reg), .stat(stat),
        .num_value(num_value), .hold_byte(hold_byte), .cmd(cmd), .ev(ev),
        .etype(et), .val(val), .dat(dat), .lvl(lvl), .done(done)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (step) begin
            ov_reg <= 1'b1;
        end else if (m_ready) begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            m_event_res <= ev; m_elem_type <= et; m_value <= val;
            m_data_out <= dat; m_level <= lvl; m_reply_done <= done;
        end
    end
endmodule
`default_nettype wire

### tb/resp_reply_stream_parser_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resp_reply_stream_parser_unit_tb
// Self-checking bench: drives RESP2 reply streams (well-formed replies with
// random content, broken ones and noise) through the parser, predicts every
// event with a behavioral parser model and checks each output transaction.
// ----------------------------------------------------------------------------
module resp_reply_stream_parser_unit_tb
    import resp_pkg::*;
();

    localparam int DEPTH = 8;
    localparam logic [0:0] REG_PIPE  = 1'b0;
    localparam logic [0:0] REG_LIMIT = 1'b1;

    typedef struct packed {
        logic [2:0]  ev;
        logic [2:0]  etype;
        logic [63:0] val;
        logic [7:0]  dat;
        logic [3:0]  lvl;
        logic        done;
    } resp_event_t;

    class event_scoreboard;
        logic [15:0] pipe_cnt;
        logic [6:0]  line_lim;
        mode_t       mode;
        logic [63:0] remain [0:DEPTH];
        logic [63:0] idx [0:DEPTH];
        logic [3:0]  top;
        logic [63:0] acc;
        logic        neg, bad, cr, serial_seen, err, hold_v;
        logic [6:0]  digits;
        logic [63:0] bulk_left;
        logic [2:0]  cur_type;
        logic [7:0]  hold_b;
        resp_event_t pending [$];
        int errors, checked, n_done, n_err_ev;

        function new();
            pipe_cnt = 1; line_lim = 32; mode = M_FRESH; top = 0;
            for (int i = 0; i <= DEPTH; i++) begin remain[i] = 0; idx[i] = 0; end
            acc = 0; neg = 0; bad = 0; cr = 0; digits = 0; bulk_left = 0;
            cur_type = 0; serial_seen = 0; err = 0; hold_v = 0; hold_b = 0;
            errors = 0; checked = 0; n_done = 0; n_err_ev = 0;
        endfunction

        function void num_clear();
            acc = 0; neg = 0; bad = 0; digits = 0; cr = 0;
        endfunction

        function void num_content(logic [7:0] b);
            if (digits == 0 && (b == CH_MINUS || b == CH_PLUS)) neg = (b == CH_MINUS);
            else if (b >= CH_0 && b <= CH_9) acc = acc * 10 + 64'(b - CH_0);
            else bad = 1;
            if (digits < 127) digits++;
        endfunction

        function logic [1:0] num_byte(logic [7:0] b);
            if (cr) begin
                cr = 0;
                if (b == CH_LF) return (digits >= line_lim) ? NR_LONG : NR_DONE;
                num_content(CH_CR);
            end
            if (b == CH_CR) cr = 1;
            else num_content(b);
            return NR_GOON;
        endfunction

        function logic [63:0] num_val();
            if (bad) return '1;
            return neg ? 64'd0 - acc : acc;
        endfunction

        function logic next_elem();
            for (int g = 0; g <= DEPTH + 1; g++) begin
                if (top == 0 || top > DEPTH) begin top = 0; return 1; end
                if (idx[top] + 1 >= remain[top - 1]) top = top - 1;
                else begin idx[top] = idx[top] + 1; return 0; end
            end
            top = 0;
            return 1;
        endfunction

        function void set_reg(logic [0:0] r, logic [15:0] d);
            if (r == REG_PIPE) pipe_cnt = d;
            else line_lim = d[6:0];
        endfunction

        function void note_input(logic [7:0] b, logic rs);
            resp_event_t e;
            logic fin, fail;
            logic [1:0] r;
            logic [63:0] v, c;
            e = '0; fin = 0; fail = 0;
            if (rs) begin err = 0; mode = M_FRESH; end
            if (!err && mode == M_FRESH) begin
                for (int i = 0; i <= DEPTH; i++) begin remain[i] = 0; idx[i] = 0; end
                top = 0; serial_seen = 0;
                if (pipe_cnt > 1) begin remain[0] = pipe_cnt; top = 1; end
                mode = M_TYPE;
            end
            e.lvl = top;
            if (err) e.ev = EV_ERROR;
            else begin
                case (mode)
                    M_TYPE, M_TYPE_NOSER: begin
                        if (b == CH_AT && mode == M_TYPE &&
                            (!serial_seen || (pipe_cnt > 1 && top == 1))) begin
                            num_clear(); mode = M_SERIAL;
                        end else begin
                            serial_seen = 1; hold_v = 0; num_clear();
                            if (b == CH_MINUS) begin cur_type = T_ERR; mode = M_LINE; end
                            else if (b == CH_PLUS) begin cur_type = T_STAT; mode = M_LINE; end
                            else if (b == CH_COLON) begin cur_type = T_INT; mode = M_NUMBER; end
                            else if (b == CH_DOLL) begin cur_type = T_BULK; mode = M_NUMBER; end
                            else if (b == CH_STAR) begin
                                cur_type = T_ARR;
                                if (top >= DEPTH) fail = 1; else mode = M_NUMBER;
                            end else begin cur_type = T_ERR; fail = 1; end
                        end
                    end
                    M_SERIAL: begin
                        r = num_byte(b);
                        if (r == NR_LONG) fail = 1;
                        else if (r == NR_DONE) begin
                            e.ev = EV_SERIAL; e.val = num_val();
                            serial_seen = 1; mode = M_TYPE_NOSER;
                        end
                    end
                    M_LINE: begin
                        if (hold_v && hold_b == CH_CR && b == CH_LF) begin
                            hold_v = 0; e.ev = EV_STREND; fin = 1;
                        end else begin
                            if (hold_v) begin e.ev = EV_DATA; e.dat = hold_b; end
                            hold_b = b; hold_v = 1;
                        end
                    end
                    M_NUMBER: begin
                        r = num_byte(b);
                        if (r == NR_LONG) fail = 1;
                        else if (r == NR_DONE) begin
                            v = num_val();
                            if (cur_type == T_BULK) begin
                                if (v[63]) begin e.ev = EV_NIL; fin = 1; end
                                else begin
                                    bulk_left = v; cr = 0;
                                    mode = (v != 0) ? M_BULK : M_TRAIL;
                                end
                            end else if (cur_type == T_ARR) begin
                                c = {{32{v[31]}}, v[31:0]};
                                if (c == '1) begin e.ev = EV_NIL; fin = 1; end
                                else if (c != 0 && !c[63] && top < DEPTH) begin
                                    e.ev = EV_ARRAY; e.val = c;
                                    remain[top] = c; top++; idx[top] = 0;
                                    mode = M_TYPE;
                                end else begin e.ev = EV_ARRAY; fin = 1; end
                            end else begin
                                e.ev = EV_INT; e.val = v; fin = 1;
                            end
                        end
                    end
                    M_BULK: begin
                        e.ev = EV_DATA; e.dat = b; bulk_left--;
                        if (bulk_left == 0) begin cr = 0; mode = M_TRAIL; end
                    end
                    M_TRAIL: begin
                        if (!cr) cr = 1;
                        else begin cr = 0; e.ev = EV_STREND; fin = 1; end
                    end
                    default: mode = M_FRESH;
                endcase
                if (fail) begin err = 1; e.ev = EV_ERROR; end
                else if (fin) begin
                    if (next_elem()) begin e.done = 1; mode = M_FRESH; end
                    else mode = M_TYPE;
                end
            end
            if (e.ev != EV_NONE && e.ev != EV_SERIAL) e.etype = cur_type;
            pending.insert(pending.size(), e);
        endfunction

        function void check_result(resp_event_t got);
            resp_event_t exp_e;
            checked++;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected transaction %h", $realtime, got);
                return;
            end
            exp_e = pending.pop_front();
            if (got.done) n_done++;
            if (got.ev == EV_ERROR) n_err_ev++;
            if (got.ev !== exp_e.ev) begin errors++;
                $display("%0t: event exp %0d got %0d", $realtime, exp_e.ev, got.ev); end
            if (got.etype !== exp_e.etype) begin errors++;
                $display("%0t: type exp %0d got %0d", $realtime, exp_e.etype, got.etype); end
            if (got.val !== exp_e.val) begin errors++;
                $display("%0t: value exp %h got %h", $realtime, exp_e.val, got.val); end
            if (got.dat !== exp_e.dat) begin errors++;
                $display("%0t: data exp %h got %h", $realtime, exp_e.dat, got.dat); end
            if (got.lvl !== exp_e.lvl) begin errors++;
                $display("%0t: level exp %0d got %0d", $realtime, exp_e.lvl, got.lvl); end
            if (got.done !== exp_e.done) begin errors++;
                $display("%0t: done exp %0d got %0d", $realtime, exp_e.done, got.done); end
        endfunction
    endclass

    logic aclk = 0, aresetn = 0;
    logic cfg_we = 0;
    logic [0:0] cfg_index = 0;
    logic [15:0] cfg_data = 0;
    logic s_valid = 0, s_restart = 0, m_ready = 0;
    logic [7:0] s_in_byte = 0;
    logic s_ready, m_valid, m_reply_done;
    logic [2:0] m_event_res, m_elem_type;
    logic signed [63:0] m_value;
    logic [7:0] m_data_out;
    logic [3:0] m_level;

    event_scoreboard sb = new();
    int idle_pct = 25;
    int sink_hold = 0;
    int sent = 0;
    logic [7:0] stream [$];

    always begin #5 aclk = 1; #5 aclk = 0; end

    resp_reply_stream_parser_unit DUT (.*);

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_result({m_event_res, m_elem_type, m_value, m_data_out,
                                 m_level, m_reply_done});
            if (sink_hold > 0) begin
                sink_hold <= sink_hold - 1;
                m_ready <= 0;
            end else
                m_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // valid stays high from one accepted transaction to the next unless idling
    task automatic send_byte(logic [7:0] b, logic rs);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1; s_in_byte <= b; s_restart <= rs;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(b, rs);
        sent++;
    endtask

    task automatic flush_stream(logic rs_first);
        logic first;
        first = rs_first;
        while (stream.size() > 0) begin
            send_byte(stream.pop_front(), first);
            first = 0;
        end
    endtask

    task automatic write_reg(logic [0:0] r, logic [15:0] d);
        s_valid <= 0;
        @(posedge aclk);
        cfg_we <= 1; cfg_index <= r; cfg_data <= d;
        @(posedge aclk);
        cfg_we <= 0;
        sb.set_reg(r, d);
    endtask

    task automatic drain();
        s_valid <= 0;
        while (sb.pending.size() > 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic put_byte(logic [7:0] b);
        stream.insert(stream.size(), b);
    endtask

    task automatic push_str(string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endtask

    task automatic push_crlf();
        put_byte(CH_CR); put_byte(CH_LF);
    endtask

    function automatic string rnd_num(bit allow_neg);
        string s;
        int n;
        s = "";
        if (allow_neg && $urandom_range(3) == 0) s = "-";
        else if ($urandom_range(7) == 0) s = "+";
        n = $urandom_range(6) == 0 ? $urandom_range(21, 1) : $urandom_range(3, 1);
        for (int i = 0; i < n; i++) s = {s, string'(8'(CH_0 + $urandom_range(9)))};
        return s;
    endfunction

    task automatic push_elem(int depth);
        int k, n;
        k = (depth >= 4) ? $urandom_range(3) : $urandom_range(5);
        if ($urandom_range(9) == 0) begin push_str("@"); push_str(rnd_num(1)); push_crlf(); end
        case (k)
            0: begin
                push_str($urandom_range(1) ? "+" : "-");
                n = $urandom_range(6);
                for (int i = 0; i < n; i++) put_byte(8'($urandom_range(255)));
                push_crlf();
            end
            1: begin push_str(":"); push_str(rnd_num(1)); push_crlf(); end
            2, 3: begin
                n = $urandom_range(5);
                if ($urandom_range(7) == 0) begin push_str("$-1"); push_crlf(); end
                else begin
                    push_str("$"); push_str($sformatf("%0d", n)); push_crlf();
                    for (int i = 0; i < n; i++) put_byte(8'($urandom_range(255)));
                    put_byte(8'($urandom_range(255))); put_byte(8'($urandom_range(255)));
                end
            end
            default: begin
                n = $urandom_range(3);
                if (depth >= 8 || $urandom_range(9) == 0) n = -$urandom_range(2);
                push_str("*"); push_str($sformatf("%0d", n)); push_crlf();
                for (int i = 0; i < n; i++) push_elem(depth + 1);
            end
        endcase
    endtask

    task automatic push_noise();
        int n;
        n = $urandom_range(8, 1);
        for (int i = 0; i < n; i++) put_byte(8'($urandom_range(255)));
    endtask

    task automatic run_random(int count);
        int t;
        while (sent < count) begin
            t = $urandom_range(99);
            if (t < 80) push_elem(sb.pipe_cnt > 1 ? 1 : 0);
            else if (t < 90) begin push_elem(0); void'(stream.pop_back()); push_noise(); end
            else push_noise();
            flush_stream(t >= 80 || $urandom_range(15) == 0);
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // directed: field extremes, status, integer, bulk and array types, serial, errors
        push_str("@7"); push_crlf(); push_str(":-9223372036854775808"); push_crlf();
        flush_stream(0);
        push_str("+a"); put_byte(8'hff); put_byte(8'h00); push_crlf();
        flush_stream(0);
        push_str("*2"); push_crlf(); push_str("$2"); push_crlf(); push_str("xy");
        push_crlf(); push_str("*-1"); push_crlf(); flush_stream(0);
        push_str(":1x"); push_crlf(); push_str("!"); push_str("abc"); flush_stream(0);
        push_str("*9"); push_crlf();
        for (int i = 0; i < 8; i++) begin push_str("*1"); push_crlf(); end
        flush_stream(1);
        push_str(":12"); push_crlf(); flush_stream(1);
        drain();
        write_reg(REG_LIMIT, 16'd2);
        push_str(":12"); push_crlf(); push_str(":1"); push_crlf(); flush_stream(1);
        drain();
        write_reg(REG_LIMIT, 16'd64);
        write_reg(REG_PIPE, 16'd3);
        push_str("@1"); push_crlf(); push_str(":5"); push_crlf();
        push_str("@2"); push_crlf(); push_str("$-1"); push_crlf();
        push_str("*0"); push_crlf(); flush_stream(0);
        drain();
        // back-pressure: sink stalls long while bytes keep coming
        sink_hold = 60;
        write_reg(REG_PIPE, 16'd1);
        run_random(sent + 100);
        drain();
        write_reg(REG_LIMIT, 16'd32);
        run_random(700);
        drain();
        idle_pct = 0;
        run_random(1000);
        drain();
        idle_pct = 25;
        write_reg(REG_PIPE, 16'd2);
        run_random(1500);
        drain();
        write_reg(REG_PIPE, 16'd65535);
        write_reg(REG_LIMIT, 16'd6);
        run_random(1900);
        drain();
        $display("summary: %0d bytes, %0d events checked, %0d replies done, %0d error events",
                 sent, sb.checked, sb.n_done, sb.n_err_ev);
        $display("covered all reply types, serial lines, nesting limit, both registers");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("resp_reply_stream_parser_unit_tb: done, clean");
        else
            $display("resp_reply_stream_parser_unit_tb: done, errors");
        $finish;
    end

    initial begin
        #5ms;
        $display("timeout");
        $display("resp_reply_stream_parser_unit_tb: done, errors");
        $finish;
    end
endmodule

### resp_reply_stream_parser_unit.f
hw/rtl/resp_pkg.sv
hw/rtl/resp_datapath.sv
hw/rtl/resp_controller.sv
hw/rtl/resp_reply_stream_parser_unit.sv
tb/resp_reply_stream_parser_unit_tb.sv
